// File: rtl/core/lifo_stack_with_search_core_assert.svh
// Assertion helpers shared by the stack core.
`ifndef LIFO_STACK_WITH_SEARCH_CORE_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lss: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lss: next-cycle check failed");

`endif

// File: rtl/core/lss_pkg.sv
package lss_pkg;

    localparam int WORD_W    = 32;
    localparam int MAX_OUT   = 16;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_SEARCH  = 2'd2,
        FUNC_DISPLAY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        t_cell_op            op;
        logic                capture;
        logic [WORD_W-1:0]   key;
    } t_cell_ctrl;

endpackage

// File: rtl/core/lifo_stack_with_search_core.sv
// LIFO stack with search, built as a chain of word cells (cell 0 is the top).
// Push and pop: one beat on the cycle after start; busy stays low (1 item/cycle).
// Search: one beat after the cells register the compare and S_SRCH encodes the hit; busy in S_SRCH.
// Display: one beat per cycle for the top min(fill, 16) words, busy while the
// chain rotates once around; an empty store gives one beat.
// Reset (synchronous, active low) empties the stack; stored words are not cleared.
`include "lifo_stack_with_search_core_assert.svh"

module lifo_stack_with_search_core #(
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_func,
    input  logic signed [lss_pkg::WORD_W-1:0]    i_operand_value,
    output logic                                 o_done,
    output logic [1:0]                           o_status,
    output logic signed [lss_pkg::WORD_W-1:0]    o_result_value,
    output logic [lss_pkg::OUT_CNT_W-1:0]        o_position,
    output logic [lss_pkg::OUT_CNT_W-1:0]        o_fill_count,
    output logic                                 o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + lss_pkg::OUT_CNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SRCH = 3'b010,
        S_DISP = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_fill, n_fill;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                r_disp_n, n_disp_n;

    logic                         r_done, n_done;
    lss_pkg::t_status             r_status, n_status;
    logic [lss_pkg::WORD_W-1:0]   r_val, n_val;
    logic [lss_pkg::OUT_CNT_W-1:0] r_pos, n_pos;
    logic [lss_pkg::OUT_CNT_W-1:0] r_ofill;
    logic                         r_last, n_last;

    lss_pkg::t_cell_ctrl          w_ctrl;
    logic [lss_pkg::WORD_W-1:0]   w_value [DEPTH];
    logic [DEPTH-1:0]             w_hit;
    logic [CW-1:0]                w_pos;
    logic [XW-1:0]                w_pos_ext;
    logic [XW-1:0]                w_fill_ext;
    logic                         w_accept;
    lss_pkg::t_func               w_func;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_func    = lss_pkg::t_func'(i_func);
    assign w_pos_ext = XW'(w_pos);
    assign w_fill_ext = XW'(n_fill);

    // Cell chain: push moves words down, pop moves them up, rotate wraps top
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [lss_pkg::WORD_W-1:0] w_above;
        logic [lss_pkg::WORD_W-1:0] w_below;

        if (g == 0) begin : g_top
            assign w_above = i_operand_value;
        end else begin : g_mid
            assign w_above = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_bot
            assign w_below = w_value[g];
        end else begin : g_inner
            assign w_below = w_value[g+1];
        end

        lss_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .i_top        (w_value[0]),
            .i_wrap       (r_fill == CW'(g + 1)),
            .i_valid      (r_fill > CW'(g)),
            .o_value      (w_value[g]),
            .o_hit        (w_hit[g])
        );
    end

    lss_prio #(
        .DEPTH (DEPTH)
    ) u_prio (
        .i_hit (w_hit),
        .o_pos (w_pos)
    );

    // Sequence operations and form the next result beat
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_cnt      = r_cnt;
        n_disp_n   = r_disp_n;
        n_done     = 1'b0;
        n_status   = lss_pkg::ST_OK;
        n_val      = '0;
        n_pos      = '0;
        n_last     = 1'b1;
        w_ctrl.op      = lss_pkg::CELL_HOLD;
        w_ctrl.capture = 1'b0;
        w_ctrl.key     = i_operand_value;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_func)
                        lss_pkg::FUNC_PUSH: begin
                            n_done = 1'b1;
                            if (r_fill == CW'(DEPTH)) begin
                                n_status = lss_pkg::ST_FULL;
                            end else begin
                                w_ctrl.op = lss_pkg::CELL_PUSH;
                                n_fill    = r_fill + CW'(1);
                                n_val     = i_operand_value;
                            end
                        end
                        lss_pkg::FUNC_POP: begin
                            n_done = 1'b1;
                            if (r_fill == '0) begin
                                n_status = lss_pkg::ST_EMPTY;
                            end else begin
                                w_ctrl.op = lss_pkg::CELL_POP;
                                n_fill    = r_fill - CW'(1);
                                n_val     = w_value[0];
                            end
                        end
                        lss_pkg::FUNC_SEARCH: begin
                            w_ctrl.capture = 1'b1;
                            n_state        = S_SRCH;
                        end
                        default: begin
                            if (r_fill == '0) begin
                                n_done   = 1'b1;
                                n_status = lss_pkg::ST_EMPTY;
                            end else begin
                                n_state  = S_DISP;
                                n_cnt    = '0;
                                n_disp_n = (XW'(r_fill) < XW'(lss_pkg::MAX_OUT)) ?
                                           r_fill : CW'(lss_pkg::MAX_OUT);
                            end
                        end
                    endcase
                end
            end
            S_SRCH: begin
                n_done  = 1'b1;
                n_pos   = w_pos_ext[lss_pkg::OUT_CNT_W-1:0];
                n_state = S_IDLE;
                if (w_pos == '0) begin
                    n_status = lss_pkg::ST_NOTFOUND;
                end
            end
            S_DISP: begin
                w_ctrl.op = lss_pkg::CELL_ROT;
                if (r_cnt < r_disp_n) begin
                    n_done = 1'b1;
                    n_val  = w_value[0];
                    n_last = (r_cnt + CW'(1) == r_disp_n);
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt + CW'(1) == r_fill) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state; clear it on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // Register the result beat payload
    always_ff @(posedge i_clk) begin
        r_disp_n <= n_disp_n;
        r_status <= n_status;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_ofill  <= w_fill_ext[lss_pkg::OUT_CNT_W-1:0];
        r_last   <= n_last;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_value = r_val;
    assign o_position     = r_pos;
    assign o_fill_count   = r_ofill;
    assign o_last         = r_last;

    `LSS_ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(DEPTH))

    `LSS_ASSERT_NEXT(a_push_ok, i_clk, i_rst_n, w_accept && (w_func == lss_pkg::FUNC_PUSH) && (r_fill != CW'(DEPTH)), o_done && o_last && (o_status == lss_pkg::ST_OK))

    `LSS_ASSERT_IMPLY(a_empty_fill, i_clk, i_rst_n, o_done && (o_status == lss_pkg::ST_EMPTY), r_fill == '0)

    `LSS_ASSERT_NEXT(a_search_beat, i_clk, i_rst_n, r_state == S_SRCH, o_done && o_last && !busy)

endmodule

// File: rtl/core/lss_cell.sv
module lss_cell (
    input  logic                             i_clk,
    input  lss_pkg::t_cell_ctrl              i_ctrl,
    input  logic [lss_pkg::WORD_W-1:0]       i_from_above,
    input  logic [lss_pkg::WORD_W-1:0]       i_from_below,
    input  logic [lss_pkg::WORD_W-1:0]       i_top,
    input  logic                             i_wrap,
    input  logic                             i_valid,
    output logic [lss_pkg::WORD_W-1:0]       o_value,
    output logic                             o_hit
);

    logic [lss_pkg::WORD_W-1:0] r_value;
    logic [lss_pkg::WORD_W-1:0] n_value;
    logic                       r_hit;

    // Pick the word this cell holds next
    always_comb begin
        case (i_ctrl.op)
            lss_pkg::CELL_PUSH: n_value = i_from_above;
            lss_pkg::CELL_POP:  n_value = i_from_below;
            lss_pkg::CELL_ROT:  n_value = i_wrap ? i_top : i_from_below;
            default:            n_value = r_value;
        endcase
    end

    // Advance the word; capture the compare result on a search
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctrl.capture) begin
            r_hit <= i_valid && (r_value == i_ctrl.key);
        end
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

// File: rtl/core/lss_prio.sv
module lss_prio #(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0]             i_hit,
    output logic [$clog2(DEPTH+1)-1:0]   o_pos
);

    localparam int PW = $clog2(DEPTH + 1);

    // Find the hit nearest the top, 1-based; zero when none
    always_comb begin
        o_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_hit[i]) begin
                o_pos = PW'(i + 1);
            end
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STACK_DEPTH = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_OPS  = 200;
    localparam int SETTLE_CYC  = 40;

    // One expected result beat
    typedef struct {
        lss_pkg::t_status                    status;
        logic signed [lss_pkg::WORD_W-1:0]   value;
        logic [lss_pkg::OUT_CNT_W-1:0]       position;
        logic [lss_pkg::OUT_CNT_W-1:0]       fill_count;
        logic                                last;
    } t_beat;

    // Stack predictor plus queue of expected beats
    class lifo_scoreboard;
        logic signed [lss_pkg::WORD_W-1:0] words [STACK_DEPTH];
        int unsigned                       fill;
        t_beat                             expected_beats [$];
        int                                mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void add_beat(lss_pkg::t_status st, logic signed [lss_pkg::WORD_W-1:0] v,
                               int unsigned pos, logic lst);
            t_beat b;
            b.status     = st;
            b.value      = v;
            b.position   = pos[lss_pkg::OUT_CNT_W-1:0];
            b.fill_count = fill[lss_pkg::OUT_CNT_W-1:0];
            b.last       = lst;
            expected_beats.push_back(b);
        endfunction

        // Apply one accepted command to the stack and queue its beats
        function void record_command(lss_pkg::t_func f,
                                     logic signed [lss_pkg::WORD_W-1:0] v);
            int unsigned n;
            int unsigned hit;
            hit = 0;
            case (f)
                lss_pkg::FUNC_PUSH: begin
                    if (fill >= STACK_DEPTH) begin
                        add_beat(lss_pkg::ST_FULL, '0, 0, 1'b1);
                    end else begin
                        words[fill] = v;
                        fill++;
                        add_beat(lss_pkg::ST_OK, v, 0, 1'b1);
                    end
                end
                lss_pkg::FUNC_POP: begin
                    if (fill == 0) begin
                        add_beat(lss_pkg::ST_EMPTY, '0, 0, 1'b1);
                    end else begin
                        fill--;
                        add_beat(lss_pkg::ST_OK, words[fill], 0, 1'b1);
                    end
                end
                lss_pkg::FUNC_SEARCH: begin
                    // first match counted from the top
                    for (int i = 0; i < fill; i++) begin
                        if (hit == 0 && words[fill - 1 - i] == v)
                            hit = i + 1;
                    end
                    if (hit != 0)
                        add_beat(lss_pkg::ST_OK, '0, hit, 1'b1);
                    else
                        add_beat(lss_pkg::ST_NOTFOUND, '0, 0, 1'b1);
                end
                default: begin
                    if (fill == 0) begin
                        add_beat(lss_pkg::ST_EMPTY, '0, 0, 1'b1);
                    end else begin
                        n = (fill < lss_pkg::MAX_OUT) ? fill : lss_pkg::MAX_OUT;
                        for (int i = 0; i < n; i++)
                            add_beat(lss_pkg::ST_OK, words[fill - 1 - i], 0, (i + 1 == n));
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [lss_pkg::WORD_W-1:0] exp_v,
                                    logic [lss_pkg::WORD_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // Compare one result beat against the oldest expectation
        function void check_beat(logic [1:0] st, logic signed [lss_pkg::WORD_W-1:0] v,
                                 logic [lss_pkg::OUT_CNT_W-1:0] pos,
                                 logic [lss_pkg::OUT_CNT_W-1:0] cnt, logic lst);
            t_beat b;
            if (expected_beats.size() == 0) begin
                $error("result beat with no expectation pending (status %0d)", st);
                mismatches++;
                return;
            end
            b = expected_beats.pop_front();
            compare_field("status", lss_pkg::WORD_W'(b.status), lss_pkg::WORD_W'(st));
            compare_field("result_value", b.value, v);
            compare_field("position", lss_pkg::WORD_W'(b.position),
                          lss_pkg::WORD_W'(pos));
            compare_field("fill_count", lss_pkg::WORD_W'(b.fill_count),
                          lss_pkg::WORD_W'(cnt));
            compare_field("last", lss_pkg::WORD_W'(b.last), lss_pkg::WORD_W'(lst));
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void close_out();
            if (expected_beats.size() != 0) begin
                $error("%0d expected beats never arrived", expected_beats.size());
                mismatches++;
            end
        endfunction
    endclass

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  start;
    logic                                  busy;
    logic [1:0]                            i_func;
    logic signed [lss_pkg::WORD_W-1:0]     i_operand_value;
    logic                                  o_done;
    logic [1:0]                            o_status;
    logic signed [lss_pkg::WORD_W-1:0]     o_result_value;
    logic [lss_pkg::OUT_CNT_W-1:0]         o_position;
    logic [lss_pkg::OUT_CNT_W-1:0]         o_fill_count;
    logic                                  o_last;

    lifo_scoreboard                        sb;
    int                                    idle_cycles;
    logic signed [lss_pkg::WORD_W-1:0]     value_pool [4];

    lifo_stack_with_search_core #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_operand_value (i_operand_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_result_value  (o_result_value),
        .o_position      (o_position),
        .o_fill_count    (o_fill_count),
        .o_last          (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Sample accepted commands and result beats at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.record_command(lss_pkg::t_func'(i_func), i_operand_value);
            if (o_done)
                sb.check_beat(o_status, o_result_value, o_position, o_fill_count,
                              o_last);
        end
    end

    // Abort when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one command and hold it until accepted
    task automatic issue_op(input lss_pkg::t_func f,
                            input logic signed [lss_pkg::WORD_W-1:0] v);
        @(negedge i_clk);
        start           <= 1'b1;
        i_func          <= f;
        i_operand_value <= v;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Drop start for a gap set by n and put noise on the payload
    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start           <= 1'b0;
            i_func          <= 2'($urandom);
            i_operand_value <= $urandom;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Hold off until every expected beat has come back
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [lss_pkg::WORD_W-1:0] pick_word();
        if ($urandom_range(0, 3) == 0)
            return value_pool[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // Bias toward growing or shrinking the stack
    function automatic lss_pkg::t_func pick_op(input bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return lss_pkg::FUNC_SEARCH;
        if (r < 30)
            return lss_pkg::FUNC_DISPLAY;
        if (growing)
            return (r < 80) ? lss_pkg::FUNC_PUSH : lss_pkg::FUNC_POP;
        return (r < 80) ? lss_pkg::FUNC_POP : lss_pkg::FUNC_PUSH;
    endfunction

    initial begin
        lss_pkg::t_func                    f;
        logic signed [lss_pkg::WORD_W-1:0] v;
        bit                                growing;
        int                                burst_left;
        int                                phase_left;

        sb              = new();
        start           <= 1'b0;
        i_func          <= lss_pkg::FUNC_PUSH;
        i_operand_value <= '0;
        i_rst_n         <= 1'b0;
        idle_cycles     <= 0;
        value_pool[0]   = 32'sh8000_0000;
        value_pool[1]   = 32'sh7fff_ffff;
        value_pool[2]   = $urandom;
        value_pool[3]   = $urandom;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, extremes, fill to full and probe the bottom
        issue_op(lss_pkg::FUNC_DISPLAY, 32'sd0);
        issue_op(lss_pkg::FUNC_POP, 32'sd0);
        issue_op(lss_pkg::FUNC_SEARCH, 32'sd0);
        issue_op(lss_pkg::FUNC_PUSH, 32'sh8000_0000);
        issue_op(lss_pkg::FUNC_PUSH, 32'sh7fff_ffff);
        issue_op(lss_pkg::FUNC_PUSH, 32'sd0);
        issue_op(lss_pkg::FUNC_PUSH, -32'sd1);
        issue_op(lss_pkg::FUNC_SEARCH, 32'sh8000_0000);
        pause_sender(2);
        issue_op(lss_pkg::FUNC_DISPLAY, 32'sd0);
        for (int i = 0; i < STACK_DEPTH - 4; i++) begin
            issue_op(lss_pkg::FUNC_PUSH, $urandom);
            pause_sender(gap_len());
        end
        issue_op(lss_pkg::FUNC_PUSH, 32'sh1234_5678);
        issue_op(lss_pkg::FUNC_DISPLAY, 32'sd0);
        issue_op(lss_pkg::FUNC_SEARCH, 32'sh8000_0000);
        issue_op(lss_pkg::FUNC_SEARCH, 32'sh1234_5678);
        issue_op(lss_pkg::FUNC_POP, 32'sd0);
        wait_drained();

        // Random: swing between full and empty with bursts of back-to-back beats
        growing    = 1'b0;
        burst_left = 0;
        phase_left = $urandom_range(15, 40);
        for (int k = 0; k < RANDOM_OPS; k++) begin
            if (sb.fill >= STACK_DEPTH && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (sb.fill == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
            if (phase_left == 0) begin
                growing    = !growing;
                phase_left = $urandom_range(15, 40);
                if ($urandom_range(0, 1) == 0)
                    wait_drained();
            end
            phase_left--;

            f = pick_op(growing);
            v = pick_word();
            if (f == lss_pkg::FUNC_SEARCH && sb.fill > 0 && $urandom_range(0, 1) == 0)
                v = sb.words[$urandom_range(0, sb.fill - 1)];
            issue_op(f, v);

            if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(0, 19) == 0) begin
                burst_left = $urandom_range(8, 24);
            end else begin
                pause_sender(gap_len());
            end
        end

        // Drain, let the block settle, then report
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/lss_pkg.sv
rtl/core/lss_cell.sv
rtl/core/lss_prio.sv
rtl/core/lifo_stack_with_search_core.sv
bench/tb_top.sv
